// File: rtl/bii_pkg.sv
// ----------------------------------------------------------------------------
// bii_pkg
// Shared widths, codes and sequencer types of the bicubic interpolator.
// ----------------------------------------------------------------------------
package bii_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int FRAC_BITS  = 8;
  localparam int PIXEL_BITS = 16;

  localparam int COORD_W = 8;
  localparam int POS_W   = 16;
  localparam int OUT_W   = 26;
  localparam int CFG_W   = 9;
  localparam int ADDR_W  = $clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT);
  localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;

  // Horner operand and accumulator widths
  localparam int Q_W   = 28;
  localparam int ACC_W = 60;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [1:0] {
    STEP_C,
    STEP_B,
    STEP_A,
    STEP_P
  } hstep_e;

  typedef struct packed {
    logic   en;
    hstep_e step;
  } horner_ctrl_t;

endpackage

// File: rtl/bicubic_image_interpolator.sv
// ----------------------------------------------------------------------------
// bicubic_image_interpolator
// Pixel store with Catmull-Rom bicubic queries on a shared Horner unit.
// ----------------------------------------------------------------------------
// Query in range: result strobe as busy falls, next item in that
//   cycle; the query is 16 store reads overlapped with the 16
//   column Horner steps, then 4 row steps, rounding and the result register.
// Query out of range: strobe on the next cycle; writes: no result.
// Reset clears the sequencer, the strobe and sets both grid sizes to 256;
//   the pixel store is not cleared. The receiver cannot stall.
module bicubic_image_interpolator
  import bii_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic                    operation_i,
  input  logic [COORD_W-1:0]      column_i,
  input  logic [COORD_W-1:0]      row_i,
  input  logic [PIXEL_BITS-1:0]   pixel_value_i,
  input  logic [POS_W-1:0]        pos_x_i,
  input  logic [POS_W-1:0]        pos_y_i,
  output logic                    result_valid_o,
  output logic signed [OUT_W-1:0] interpolated_o,
  output logic                    in_range_o,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int CNT_W = 5;
  localparam logic [CNT_W-1:0] CNT_RD_END    = CNT_W'(16);
  localparam logic [CNT_W-1:0] CNT_COL_FIRST = CNT_W'(5);
  localparam logic [CNT_W-1:0] CNT_COL_LAST  = CNT_W'(20);
  localparam logic [CNT_W-1:0] CNT_CAP_FIRST = CNT_W'(9);
  localparam logic [CNT_W-1:0] CNT_CAP_LAST  = CNT_W'(21);
  localparam logic [CNT_W-1:0] CNT_ROW_FIRST = CNT_W'(22);
  localparam logic [CNT_W-1:0] CNT_ROW_LAST  = CNT_W'(25);
  localparam logic [CNT_W-1:0] CNT_DONE      = CNT_W'(26);

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] W_MAX = CFG_W'(MAX_WIDTH);
  localparam logic [CFG_W-1:0] H_MAX = CFG_W'(MAX_HEIGHT);

  localparam logic signed [ACC_W-1:0] COL_HALF = ACC_W'(1) << (2 * FRAC_BITS);
  localparam logic signed [ACC_W-1:0] ROW_HALF = ACC_W'(1) << (3 * FRAC_BITS);
  localparam logic signed [ACC_W-1:0] OUT_MAX  = (ACC_W'(1) << (OUT_W - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] OUT_MIN  = -(ACC_W'(1) << (OUT_W - 1));

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e                  state_q, state_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic                    res_vld_q, res_vld_d;
  logic signed [OUT_W-1:0] interp_q, interp_d;
  logic                    in_rng_q, in_rng_d;

  logic [CFG_W-1:0] grid_width_q, grid_height_q;

  logic [COORD_W-1:0]   ix_q, iy_q;
  logic [FRAC_BITS-1:0] fx_q, fy_q;
  logic                 nzx_q, nzy_q;
  logic [PIXEL_BITS-1:0] samp_q [3];
  logic [PIXEL_BITS-1:0] wq_q [4];
  logic signed [Q_W-1:0] cv_q [4];

  logic                  accept, cfg_wr;
  logic [CFG_W-1:0]      w_eff, h_eff;
  logic [COORD_W-1:0]    ix, iy;
  logic                  nzx, nzy;
  logic [CFG_W:0]        last_col, last_row;
  logic                  query_in_range;

  logic                  mem_we, mem_re;
  logic [ADDR_W-1:0]     mem_waddr, mem_raddr;
  logic [PIXEL_BITS-1:0] mem_rdata;

  logic [CNT_W-1:0] samp_idx, col_off, row_off, cap_off;
  logic             run, samp_en, col_phase, row_phase, cap_en;

  horner_ctrl_t            h_ctrl;
  logic signed [Q_W-1:0]   h_q [4];
  logic [FRAC_BITS-1:0]    h_u;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] col_sum, col_shift, row_sum, row_shift;
  logic signed [OUT_W-1:0] row_sat;

  function automatic logic [COORD_W-1:0] tap_sel(input logic [COORD_W-1:0] b,
                                                 input logic nz,
                                                 input logic [1:0] i);
    logic [COORD_W-1:0] mid;
    mid = b + {{(COORD_W-1){1'b0}}, nz};
    case (i)
      2'd0:    tap_sel = b - COORD_W'(1);
      2'd1:    tap_sel = b;
      2'd2:    tap_sel = mid;
      default: tap_sel = mid + COORD_W'(1);
    endcase
  endfunction

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[2])
      REG_HEIGHT: prdata = {{(32-CFG_W){1'b0}}, grid_height_q};
      default:    prdata = {{(32-CFG_W){1'b0}}, grid_width_q};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= W_MAX;
      grid_height_q <= H_MAX;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_WIDTH) begin
        grid_width_q <= pwdata[CFG_W-1:0];
      end else begin
        grid_height_q <= pwdata[CFG_W-1:0];
      end
    end
  end

  // query decode
  assign accept = start && !busy;
  assign ix     = pos_x_i[POS_W-1:FRAC_BITS];
  assign iy     = pos_y_i[POS_W-1:FRAC_BITS];
  assign nzx    = |pos_x_i[FRAC_BITS-1:0];
  assign nzy    = |pos_y_i[FRAC_BITS-1:0];
  assign w_eff  = (grid_width_q > W_MAX) ? W_MAX : grid_width_q;
  assign h_eff  = (grid_height_q > H_MAX) ? H_MAX : grid_height_q;
  assign last_col = {2'b00, ix} + {{CFG_W{1'b0}}, nzx} + (CFG_W+1)'(1);
  assign last_row = {2'b00, iy} + {{CFG_W{1'b0}}, nzy} + (CFG_W+1)'(1);
  assign query_in_range = (ix != '0) && (iy != '0) &&
                          (last_col < {1'b0, w_eff}) && (last_row < {1'b0, h_eff});

  // pixel store
  assign run       = (state_q == ST_RUN);
  assign mem_we    = accept && (operation_i == OP_WRITE);
  assign mem_waddr = {row_i, column_i};
  assign mem_re    = run && (cnt_q < CNT_RD_END);
  assign mem_raddr = {tap_sel(iy_q, nzy_q, cnt_q[1:0]), tap_sel(ix_q, nzx_q, cnt_q[3:2])};

  bii_pixel_store u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (pixel_value_i),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // schedule
  assign samp_idx  = cnt_q - CNT_W'(1);
  assign col_off   = cnt_q - CNT_COL_FIRST;
  assign row_off   = cnt_q - CNT_ROW_FIRST;
  assign cap_off   = cnt_q - CNT_CAP_FIRST;
  assign samp_en   = run && (cnt_q != '0) && (cnt_q <= CNT_RD_END);
  assign col_phase = run && (cnt_q >= CNT_COL_FIRST) && (cnt_q <= CNT_COL_LAST);
  assign row_phase = run && (cnt_q >= CNT_ROW_FIRST) && (cnt_q <= CNT_ROW_LAST);
  assign cap_en    = run && (cnt_q >= CNT_CAP_FIRST) && (cnt_q <= CNT_CAP_LAST) &&
                     (cap_off[1:0] == 2'd0);

  always_comb begin
    h_ctrl.en   = col_phase || row_phase;
    h_ctrl.step = row_phase ? hstep_e'(row_off[1:0]) : hstep_e'(col_off[1:0]);
    h_u         = row_phase ? fx_q : fy_q;
    for (int k = 0; k < 4; k++) begin
      h_q[k] = row_phase ? cv_q[k] : $signed({{(Q_W-PIXEL_BITS){1'b0}}, wq_q[k]});
    end
  end

  bii_horner u_horner (
    .clk_i  (clk_i),
    .ctrl_i (h_ctrl),
    .q_i    (h_q),
    .u_i    (h_u),
    .acc_o  (acc)
  );

  // rounding, half up, then saturation to the output width
  always_comb begin
    col_sum   = acc + COL_HALF;
    col_shift = col_sum >>> (2 * FRAC_BITS + 1);
    row_sum   = acc + ROW_HALF;
    row_shift = row_sum >>> (3 * FRAC_BITS + 1);
    if (row_shift > OUT_MAX) begin
      row_sat = OUT_MAX[OUT_W-1:0];
    end else if (row_shift < OUT_MIN) begin
      row_sat = OUT_MIN[OUT_W-1:0];
    end else begin
      row_sat = row_shift[OUT_W-1:0];
    end
  end

  // operand registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ix_q  <= ix;
      iy_q  <= iy;
      fx_q  <= pos_x_i[FRAC_BITS-1:0];
      fy_q  <= pos_y_i[FRAC_BITS-1:0];
      nzx_q <= nzx;
      nzy_q <= nzy;
    end
    if (samp_en) begin
      if (samp_idx[1:0] == 2'd3) begin
        wq_q[0] <= samp_q[0];
        wq_q[1] <= samp_q[1];
        wq_q[2] <= samp_q[2];
        wq_q[3] <= mem_rdata;
      end else begin
        samp_q[samp_idx[1:0]] <= mem_rdata;
      end
    end
    if (cap_en) begin
      cv_q[cap_off[3:2]] <= col_shift[Q_W-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    res_vld_d = 1'b0;
    interp_d  = interp_q;
    in_rng_d  = in_rng_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (operation_i == OP_QUERY)) begin
          if (query_in_range) begin
            state_d = ST_RUN;
            cnt_d   = '0;
          end else begin
            res_vld_d = 1'b1;
            interp_d  = '0;
            in_rng_d  = 1'b0;
          end
        end
      end
      ST_RUN: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_DONE) begin
          state_d   = ST_IDLE;
          res_vld_d = 1'b1;
          interp_d  = row_sat;
          in_rng_d  = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      res_vld_q <= 1'b0;
      interp_q  <= '0;
      in_rng_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      res_vld_q <= res_vld_d;
      interp_q  <= interp_d;
      in_rng_q  <= in_rng_d;
    end
  end

  assign busy           = run;
  assign result_valid_o = res_vld_q;
  assign interpolated_o = interp_q;
  assign in_range_o     = in_rng_q;

`ifndef SYNTHESIS
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !in_range_o |-> interpolated_o == '0)
    else $error("out-of-range result carries a non-zero value");

  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (operation_i == OP_WRITE) |=> !busy && !result_valid_o)
    else $error("write item started a query or gave a result");

  a_done_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> result_valid_o && in_range_o)
    else $error("query finished without an in-range result");
`endif

endmodule

// File: rtl/bii_pixel_store.sv
// ----------------------------------------------------------------------------
// bii_pixel_store
// Pixel memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bii_pixel_store
  import bii_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [ADDR_W-1:0]     waddr_i,
  input  logic [PIXEL_BITS-1:0] wdata_i,
  input  logic                  re_i,
  input  logic [ADDR_W-1:0]     raddr_i,
  output logic [PIXEL_BITS-1:0] rdata_o
);

  logic [PIXEL_BITS-1:0] mem_q [DEPTH];
  logic [PIXEL_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/bii_horner.sv
// ----------------------------------------------------------------------------
// bii_horner
// Shared multiply-add unit: one Catmull-Rom cubic in four Horner steps.
// ----------------------------------------------------------------------------
module bii_horner
  import bii_pkg::*;
(
  input  logic                    clk_i,
  input  horner_ctrl_t            ctrl_i,
  input  logic signed [Q_W-1:0]   q_i [4],
  input  logic [FRAC_BITS-1:0]    u_i,
  output logic signed [ACC_W-1:0] acc_o
);

  logic signed [ACC_W-1:0]           qe [4];
  logic signed [ACC_W-1:0]           coef_a, coef_b, coef_c, diff12;
  logic signed [ACC_W-1:0]           addend;
  logic signed [ACC_W+FRAC_BITS:0]   prod;
  logic signed [ACC_W-1:0]           acc_d, acc_q;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      qe[k] = {{(ACC_W-Q_W){q_i[k][Q_W-1]}}, q_i[k]};
    end
    coef_a = qe[2] - qe[0];
    coef_b = (qe[0] <<< 1) - ((qe[1] <<< 2) + qe[1]) + (qe[2] <<< 2) - qe[3];
    diff12 = qe[1] - qe[2];
    coef_c = (diff12 <<< 1) + diff12 + qe[3] - qe[0];
    prod   = acc_q * $signed({1'b0, u_i});
    case (ctrl_i.step)
      STEP_B:  addend = coef_b <<< FRAC_BITS;
      STEP_A:  addend = coef_a <<< (2 * FRAC_BITS);
      STEP_P:  addend = qe[1] <<< (3 * FRAC_BITS + 1);
      default: addend = coef_c;
    endcase
    if (ctrl_i.step == STEP_C) begin
      acc_d = addend;
    end else begin
      acc_d = prod[ACC_W-1:0] + addend;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

// File: dv/tb_bicubic_image_interpolator.sv
// ----------------------------------------------------------------------------
// tb_bicubic_image_interpolator
// Pixel writes and Catmull-Rom queries checked against a mirror of the pixel
// store and a fixed-point bicubic predictor. The grid size is reprogrammed
// between phases, and start is dropped at random in phases with gaps on.
// ----------------------------------------------------------------------------
module tb_bicubic_image_interpolator;
  import bii_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 40;
  localparam int HOT_SPAN    = 8;

  localparam logic [2:0] ADDR_GRID_WIDTH  = 3'd0;
  localparam logic [2:0] ADDR_GRID_HEIGHT = 3'd4;

  localparam longint ONE_F   = longint'(1) << FRAC_BITS;
  localparam longint OUT_MAX = (longint'(1) << (OUT_W - 1)) - 1;
  localparam longint OUT_MIN = -(longint'(1) << (OUT_W - 1));

  typedef struct packed {
    logic                  op;
    logic [COORD_W-1:0]    column;
    logic [COORD_W-1:0]    row;
    logic [PIXEL_BITS-1:0] pixel;
    logic [POS_W-1:0]      pos_x;
    logic [POS_W-1:0]      pos_y;
  } pixel_cmd_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] value;
    logic                    in_range;
  } interp_t;

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    start         = 1'b0;
  logic                    busy;
  logic                    operation_i   = 1'b0;
  logic [COORD_W-1:0]      column_i      = '0;
  logic [COORD_W-1:0]      row_i         = '0;
  logic [PIXEL_BITS-1:0]   pixel_value_i = '0;
  logic [POS_W-1:0]        pos_x_i       = '0;
  logic [POS_W-1:0]        pos_y_i       = '0;
  logic                    result_valid_o;
  logic signed [OUT_W-1:0] interpolated_o;
  logic                    in_range_o;
  logic                    psel          = 1'b0;
  logic                    penable       = 1'b0;
  logic                    pwrite        = 1'b0;
  logic [2:0]              paddr         = '0;
  logic [31:0]             pwdata        = '0;
  logic [31:0]             prdata;
  logic                    pready;

  logic [PIXEL_BITS-1:0] pixel_mirror [DEPTH];
  bit                    pixel_known  [DEPTH];
  logic [CFG_W-1:0]      grid_w_reg = 9'd256;
  logic [CFG_W-1:0]      grid_h_reg = 9'd256;

  pixel_cmd_t  pending_cmds[$];
  interp_t     expected_results[$];
  pixel_cmd_t  cur_cmd = '0;
  bit          cmd_loaded;
  bit          gaps_on = 1'b1;
  bit          checker_fill;
  bit          failed;
  int          hot_x;
  int          hot_y;
  int unsigned cycle_count;

  bicubic_image_interpolator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .operation_i    (operation_i),
    .column_i       (column_i),
    .row_i          (row_i),
    .pixel_value_i  (pixel_value_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .result_valid_o (result_valid_o),
    .interpolated_o (interpolated_o),
    .in_range_o     (in_range_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #1 clk_i = ~clk_i;

  function automatic int grid_limit(logic [CFG_W-1:0] cfg, int max_size);
    return (int'(cfg) > max_size) ? max_size : int'(cfg);
  endfunction

  function automatic int pixel_addr(int col, int row);
    return row * MAX_WIDTH + col;
  endfunction

  // taps i-1, i, i, i+1 on an integer position, else i-1 .. i+2
  function automatic int tap_at(logic [POS_W-1:0] pos, int k);
    int base;
    int step;
    base = int'(pos >> FRAC_BITS);
    step = (pos[FRAC_BITS-1:0] != '0) ? 1 : 0;
    case (k)
      0: return base - 1;
      1: return base;
      2: return base + step;
      default: return base + step + 1;
    endcase
  endfunction

  function automatic bit window_inside(logic [POS_W-1:0] px, logic [POS_W-1:0] py);
    return tap_at(px, 1) >= 1 && tap_at(py, 1) >= 1 &&
           tap_at(px, 3) < grid_limit(grid_w_reg, MAX_WIDTH) &&
           tap_at(py, 3) < grid_limit(grid_h_reg, MAX_HEIGHT);
  endfunction

  function automatic longint tap_pixel(int col, int row);
    return longint'(pixel_mirror[pixel_addr(col, row)]);
  endfunction

  // exact Horner cubic, scaled by 2^(3*FRAC_BITS+1)
  function automatic longint catmull_rom(longint p0, longint p1, longint p2, longint p3,
                                         longint u);
    longint a;
    longint b;
    longint c;
    longint inner;
    longint mid;
    a = p2 - p0;
    b = 2 * p0 - 5 * p1 + 4 * p2 - p3;
    c = 3 * (p1 - p2) + p3 - p0;
    inner = b * ONE_F + u * c;
    mid = a * ONE_F * ONE_F + u * inner;
    return 2 * p1 * ONE_F * ONE_F * ONE_F + u * mid;
  endfunction

  function automatic longint round_half(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic interp_t predict_query(logic [POS_W-1:0] px, logic [POS_W-1:0] py);
    interp_t res;
    longint  col_val [4];
    longint  acc;
    longint  fx;
    longint  fy;
    int      cx;
    res = '0;
    fx = longint'(px[FRAC_BITS-1:0]);
    fy = longint'(py[FRAC_BITS-1:0]);
    if (!window_inside(px, py)) return res;
    for (int i = 0; i < 4; i++) begin
      cx = tap_at(px, i);
      col_val[i] = round_half(catmull_rom(tap_pixel(cx, tap_at(py, 0)),
                                          tap_pixel(cx, tap_at(py, 1)),
                                          tap_pixel(cx, tap_at(py, 2)),
                                          tap_pixel(cx, tap_at(py, 3)), fy),
                              2 * FRAC_BITS + 1);
    end
    acc = round_half(catmull_rom(col_val[0], col_val[1], col_val[2], col_val[3], fx),
                     3 * FRAC_BITS + 1);
    if (acc > OUT_MAX) acc = OUT_MAX;
    if (acc < OUT_MIN) acc = OUT_MIN;
    res.value = acc[OUT_W-1:0];
    res.in_range = 1'b1;
    return res;
  endfunction

  function automatic logic [PIXEL_BITS-1:0] pick_pixel(int col, int row);
    if (checker_fill) return ((col + row) % 2 != 0) ? '1 : '0;
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      default: return PIXEL_BITS'($urandom);
    endcase
  endfunction

  // unused fields of an item carry random junk
  function automatic pixel_cmd_t noise_cmd();
    pixel_cmd_t c;
    c.op = 1'($urandom_range(1));
    c.column = COORD_W'($urandom);
    c.row = COORD_W'($urandom);
    c.pixel = PIXEL_BITS'($urandom);
    c.pos_x = POS_W'($urandom);
    c.pos_y = POS_W'($urandom);
    return c;
  endfunction

  function automatic logic [POS_W-1:0] hot_pos(int origin);
    logic [POS_W-1:0] p;
    p[POS_W-1:FRAC_BITS] = (POS_W-FRAC_BITS)'(origin + $urandom_range(HOT_SPAN - 1));
    p[FRAC_BITS-1:0] = ($urandom_range(3) == 0) ? '0 :
                       FRAC_BITS'($urandom_range((1 << FRAC_BITS) - 1, 1));
    return p;
  endfunction

  task automatic push_write(int col, int row, logic [PIXEL_BITS-1:0] value);
    pixel_cmd_t c;
    c = noise_cmd();
    c.op = OP_WRITE;
    c.column = col[COORD_W-1:0];
    c.row = row[COORD_W-1:0];
    c.pixel = value;
    pixel_known[pixel_addr(col, row)] = 1'b1;
    pending_cmds.push_back(c);
  endtask

  // taps of an in-range query that were never written are loaded first
  task automatic push_query(logic [POS_W-1:0] px, logic [POS_W-1:0] py);
    pixel_cmd_t c;
    if (window_inside(px, py)) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          if (!pixel_known[pixel_addr(tap_at(px, i), tap_at(py, j))])
            push_write(tap_at(px, i), tap_at(py, j), pick_pixel(tap_at(px, i), tap_at(py, j)));
        end
      end
    end
    c = noise_cmd();
    c.op = OP_QUERY;
    c.pos_x = px;
    c.pos_y = py;
    pending_cmds.push_back(c);
  endtask

  task automatic push_random_cmd();
    int roll;
    roll = $urandom_range(99);
    if (roll < 15) begin
      push_write($urandom_range(MAX_WIDTH - 1), $urandom_range(MAX_HEIGHT - 1),
                 pick_pixel(0, 0));
    end else if (roll < 25) begin
      push_write(hot_x + $urandom_range(HOT_SPAN + 1), hot_y + $urandom_range(HOT_SPAN + 1),
                 pick_pixel(0, 0));
    end else if (roll < 94) begin
      push_query(hot_pos(hot_x), hot_pos(hot_y));
    end else begin
      push_query(POS_W'($urandom), POS_W'($urandom));
    end
  endtask

  task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_cmds.size() != 0 || cmd_loaded || start || busy ||
           expected_results.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic run_phase(int w_val, int h_val, int budget, bit gaps);
    int w_lim;
    int h_lim;
    wait_idle();
    cfg_write(ADDR_GRID_WIDTH, ($urandom & ~32'h1FF) | (w_val & 32'h1FF));
    grid_w_reg = w_val[CFG_W-1:0];
    cfg_write(ADDR_GRID_HEIGHT, ($urandom & ~32'h1FF) | (h_val & 32'h1FF));
    grid_h_reg = h_val[CFG_W-1:0];
    gaps_on = gaps;
    w_lim = grid_limit(grid_w_reg, MAX_WIDTH);
    h_lim = grid_limit(grid_h_reg, MAX_HEIGHT);
    hot_x = $urandom_range(w_lim > HOT_SPAN + 2 ? w_lim - HOT_SPAN - 2 : 0);
    hot_y = $urandom_range(h_lim > HOT_SPAN + 2 ? h_lim - HOT_SPAN - 2 : 0);
    while (pending_cmds.size() < budget) push_random_cmd();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      cmd_loaded = 1'b0;
    end else begin
      if (start && !busy) begin
        if (cur_cmd.op == OP_QUERY)
          expected_results.push_back(predict_query(cur_cmd.pos_x, cur_cmd.pos_y));
        else
          pixel_mirror[pixel_addr(int'(cur_cmd.column), int'(cur_cmd.row))] = cur_cmd.pixel;
        cmd_loaded = 1'b0;
      end
      if (!cmd_loaded && pending_cmds.size() != 0) begin
        cur_cmd = pending_cmds.pop_front();
        cmd_loaded = 1'b1;
      end
      start         <= cmd_loaded && !(gaps_on && $urandom_range(99) < 22);
      operation_i   <= cur_cmd.op;
      column_i      <= cur_cmd.column;
      row_i         <= cur_cmd.row;
      pixel_value_i <= cur_cmd.pixel;
      pos_x_i       <= cur_cmd.pos_x;
      pos_y_i       <= cur_cmd.pos_y;
    end
  end

  always @(posedge clk_i) begin : result_check
    interp_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: interpolated %0d, in_range %0b", interpolated_o, in_range_o);
        failed = 1'b1;
      end else begin
        want = expected_results.pop_front();
        if (interpolated_o !== want.value) begin
          $error("interpolated: expected %0d, got %0d", want.value, interpolated_o);
          failed = 1'b1;
        end
        if (in_range_o !== want.in_range) begin
          $error("in_range: expected %0b, got %0b", want.in_range, in_range_o);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: checkerboard taps, integer and fractional positions, borders
    checker_fill = 1'b1;
    push_query(16'h0100, 16'h0100);
    push_query(16'h0180, 16'h0180);
    push_query(16'h01FF, 16'h0101);
    push_query(16'h0101, 16'h01FF);
    push_query(16'h0200, 16'h0140);
    push_query(16'h0080, 16'h0180);
    push_query(16'h0180, 16'h0000);
    push_query(16'hFFFF, 16'hFFFF);
    push_query(16'hFC80, 16'h0180);
    push_query(16'hFD01, 16'hFD40);
    push_query(16'hFE00, 16'hFE00);
    push_query(16'hFE01, 16'h0100);
    push_query(16'hFF00, 16'h0100);
    push_write(1, 1, '1);
    push_query(16'h0100, 16'h0100);
    push_query(16'h0180, 16'h0180);
    checker_fill = 1'b0;

    run_phase(4, 4, 60, 1'b1);
    run_phase(511, 300, 200, 1'b0);
    run_phase(0, 511, 20, 1'b1);
    run_phase($urandom_range(40, 4), $urandom_range(40, 4), 220, 1'b1);
    run_phase(256, 256, 150, 1'b1);
    wait_idle();

    if (!failed && expected_results.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// File: sim.f
rtl/bii_pkg.sv
rtl/bii_pixel_store.sv
rtl/bii_horner.sv
rtl/bicubic_image_interpolator.sv
dv/tb_bicubic_image_interpolator.sv
